[hw/rtl/xmodem_block_receiver_unit_defines.svh]
// Assertion macros for the checker in xmbr_checker.sv.
`ifndef XMODEM_BLOCK_RECEIVER_UNIT_DEFINES_SVH
`define XMODEM_BLOCK_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define XMBR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xmbr check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define XMBR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xmbr check failed");

`endif

[hw/rtl/xmbr_pkg.sv]
package xmbr_pkg;

	// Line control characters
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_C   = 8'h43;

	// Input op codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_BYTE  = 1'b1;

	// Session status codes
	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_RCAN = 2'd3;

	// Number plus complement must hit this exactly
	localparam logic [8:0] COMP_SUM = 9'd255;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       reply_valid;
		logic [7:0] reply_byte;
		logic [3:0] reply_repeat;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       block_commit;
		logic       block_discard;
		logic [1:0] status;
	} rsp_t;

	// Byte class decided by the front end
	typedef enum logic [2:0] {
		CLS_START,
		CLS_SOH,
		CLS_EOT,
		CLS_CAN,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_WAIT,
		PH_CAN1,
		PH_EOT,
		PH_NUM,
		PH_COMP,
		PH_DATA,
		PH_CHK1,
		PH_CHK2,
		PH_DONE,
		PH_SCAN,
		PH_RCAN
	} phase_t;

	// CRC-16/XMODEM, one byte, MSB first
	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[hw/rtl/xmbr_front.sv]
module xmbr_front
	import xmbr_pkg::*;
(
	input  logic  rx_valid,
	output logic  rx_ready,
	input  item_t rx_item,
	input  logic  full,
	output logic  push,
	output cmd_t  push_cmd
);

	// Take a beat whenever the queue has room
	assign rx_ready = !full;
	assign push     = rx_valid && !full;

	// Sort the beat into the classes the back end acts on
	always_comb begin
		push_cmd.data = rx_item.rx_byte;
		if (rx_item.op == OP_START) begin
			push_cmd.cls = CLS_START;
		end else begin
			unique case (rx_item.rx_byte)
				CH_SOH:  push_cmd.cls = CLS_SOH;
				CH_EOT:  push_cmd.cls = CLS_EOT;
				CH_CAN:  push_cmd.cls = CLS_CAN;
				default: push_cmd.cls = CLS_OTHER;
			endcase
		end
	end

endmodule

[hw/rtl/xmbr_queue.sv]
module xmbr_queue
	import xmbr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output cmd_t head
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[hw/rtl/xmbr_back.sv]
module xmbr_back
	import xmbr_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 128,
	parameter int CANCEL_REPEAT = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic use_crc,
	input  logic not_empty,
	input  cmd_t head,
	output logic pop,
	output logic res_valid,
	input  logic res_ready,
	output rsp_t res_item
);

	localparam int CW = $clog2(PAYLOAD_BYTES);

	phase_t      phase_q, phase_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [7:0]  num_q, num_d;
	logic [7:0]  comp_q, comp_d;
	logic [7:0]  last_q, last_d;
	logic [15:0] acc_q, acc_d;
	logic [7:0]  chk1_q, chk1_d;
	logic        res_valid_q;
	rsp_t        res_q, rsp_d;

	logic [7:0]  expect_num;
	logic        check_ok;
	logic        blk_end;

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// Pop when the output register is free or being drained
	assign pop = not_empty && (!res_valid_q || res_ready);

	assign expect_num = last_q + 8'd1;

	// Check compare for the current check byte
	always_comb begin
		if (phase_q == PH_CHK2) begin
			check_ok = ({chk1_q, head.data} == acc_q);
		end else begin
			check_ok = (acc_q[7:0] == head.data);
		end
	end

	// Session sequencer
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		num_d   = num_q;
		comp_d  = comp_q;
		last_d  = last_q;
		acc_d   = acc_q;
		chk1_d  = chk1_q;
		blk_end = 1'b0;
		rsp_d   = '0;
		rsp_d.reply_repeat = 4'd1;

		if (head.cls == CLS_START) begin
			phase_d = PH_WAIT;
			cnt_d   = '0;
			num_d   = '0;
			comp_d  = '0;
			last_d  = '0;
			acc_d   = '0;
			chk1_d  = '0;
			rsp_d.reply_valid = 1'b1;
			rsp_d.reply_byte  = use_crc ? CH_C : CH_NAK;
		end else begin
			unique case (phase_q)
				PH_WAIT: begin
					case (head.cls)
						CLS_SOH: begin
							phase_d = PH_NUM;
							cnt_d   = '0;
							acc_d   = '0;
						end
						CLS_EOT: begin
							rsp_d.reply_valid = 1'b1;
							rsp_d.reply_byte  = CH_NAK;
							phase_d = PH_EOT;
						end
						CLS_CAN: phase_d = PH_CAN1;
						default: ;
					endcase
				end
				PH_CAN1: phase_d = (head.cls == CLS_CAN) ? PH_SCAN : PH_WAIT;
				PH_EOT: begin
					if (head.cls == CLS_EOT) begin
						rsp_d.reply_valid = 1'b1;
						rsp_d.reply_byte  = CH_ACK;
						phase_d = PH_DONE;
					end
				end
				PH_NUM: begin
					num_d   = head.data;
					phase_d = PH_COMP;
				end
				PH_COMP: begin
					comp_d  = head.data;
					phase_d = PH_DATA;
				end
				PH_DATA: begin
					rsp_d.data_valid = 1'b1;
					rsp_d.data_byte  = head.data;
					if (use_crc) begin
						acc_d = crc16_update(acc_q, head.data);
					end else begin
						acc_d = {8'h00, acc_q[7:0] + head.data};
					end
					if (cnt_q == CW'(PAYLOAD_BYTES - 1)) begin
						cnt_d   = '0;
						phase_d = PH_CHK1;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
				PH_CHK1: begin
					if (use_crc) begin
						chk1_d  = head.data;
						phase_d = PH_CHK2;
					end else begin
						blk_end = 1'b1;
					end
				end
				PH_CHK2: blk_end = 1'b1;
				default: ;
			endcase
		end

		// Block verdict: complement, sequence, then check
		if (blk_end) begin
			rsp_d.reply_valid = 1'b1;
			phase_d = PH_WAIT;
			if (({1'b0, num_q} + {1'b0, comp_q}) != COMP_SUM) begin
				rsp_d.reply_byte    = CH_NAK;
				rsp_d.block_discard = 1'b1;
			end else if (num_q != expect_num) begin
				rsp_d.block_discard = 1'b1;
				if (num_q == last_q) begin
					rsp_d.reply_byte = CH_ACK;
				end else begin
					rsp_d.reply_byte   = CH_CAN;
					rsp_d.reply_repeat = 4'(CANCEL_REPEAT);
					phase_d = PH_RCAN;
				end
			end else if (check_ok) begin
				rsp_d.reply_byte   = CH_ACK;
				rsp_d.block_commit = 1'b1;
				last_d = expect_num;
			end else begin
				rsp_d.reply_byte    = CH_NAK;
				rsp_d.block_discard = 1'b1;
			end
		end

		// Status follows the phase left behind
		unique case (phase_d)
			PH_DONE: rsp_d.status = ST_DONE;
			PH_SCAN: rsp_d.status = ST_SCAN;
			PH_RCAN: rsp_d.status = ST_RCAN;
			default: rsp_d.status = ST_RUN;
		endcase
	end

	// Session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			num_q   <= '0;
			comp_q  <= '0;
			last_q  <= '0;
			acc_q   <= '0;
			chk1_q  <= '0;
		end else if (pop) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			num_q   <= num_d;
			comp_q  <= comp_d;
			last_q  <= last_d;
			acc_q   <= acc_d;
			chk1_q  <= chk1_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= rsp_d;
		end
	end

endmodule

[hw/rtl/xmodem_block_receiver_unit.sv]
// XMODEM block receiver: one line byte (or a start command) per rx beat, exactly one
// result beat per rx beat, in order. Sustained rate is one byte per clock while
// res_ready stays high; a byte's result is registered first in the two-entry queue
// between the byte classifier and the protocol sequencer, then in the output
// register. The sequencer's per-cycle work is set by the bytewise CRC-16
// update and the block verdict compare. use_crc resets to 1 and is written through
// the cfg channel, which is always ready; write it only while no byte is in flight.
module xmodem_block_receiver_unit
	import xmbr_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 128,
	parameter int CANCEL_REPEAT = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  rx_valid,
	output logic  rx_ready,
	input  item_t rx_item,
	output logic  res_valid,
	input  logic  res_ready,
	output rsp_t  res_item,
	input  logic  cfg_valid,
	output logic  cfg_ready,
	input  logic  cfg_data
);

	logic use_crc_q;
	logic full;
	logic push;
	logic pop;
	logic not_empty;
	cmd_t push_cmd;
	cmd_t head;

	// Mode register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_crc_q <= 1'b1;
		end else if (cfg_valid) begin
			use_crc_q <= cfg_data;
		end
	end

	xmbr_front u_front (
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_item  (rx_item),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	xmbr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	xmbr_back #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES),
		.CANCEL_REPEAT (CANCEL_REPEAT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.use_crc   (use_crc_q),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule

[hw/rtl/xmbr_checker.sv]
`include "xmodem_block_receiver_unit_defines.svh"

module xmbr_checker
	import xmbr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input rsp_t res_item
);

	// A stalled result beat holds
	`XMBR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_item))

	// A block verdict always carries a reply and no data byte
	`XMBR_ASSERT_NOW(a_verdict_reply, res_valid && (res_item.block_commit || res_item.block_discard), res_item.reply_valid && !res_item.data_valid && !(res_item.block_commit && res_item.block_discard))

	// A CAN reply ends the session as cancelled by receiver
	`XMBR_ASSERT_NOW(a_can_status, res_valid && res_item.reply_valid && (res_item.reply_byte == CH_CAN), res_item.status == ST_RCAN && res_item.block_discard)

	// Only a cancel repeats its reply
	`XMBR_ASSERT_NOW(a_repeat_can, res_valid && (res_item.reply_repeat != 4'd1), res_item.reply_valid && (res_item.reply_byte == CH_CAN))

endmodule

bind xmodem_block_receiver_unit xmbr_checker u_xmbr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_item  (res_item)
);

[bench/tb_xmodem_block_receiver_unit.sv]
`timescale 1ns / 100ps

module tb_xmodem_block_receiver_unit;
	import xmbr_pkg::*;

	localparam int PAYLOAD_LEN = 128;
	localparam int CANCEL_LEN = 8;
	localparam int ITEM_TARGET = 1200;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 250;

	// Bytes that mean something on the line, used to salt payloads
	localparam logic [7:0] LINE_CODES [6] = '{CH_SOH, CH_EOT, CH_ACK, CH_NAK, CH_CAN, CH_C};

	typedef enum {
		BLK_GOOD,
		BLK_DUP,
		BLK_BAD_COMP,
		BLK_BAD_CHECK,
		BLK_BAD_NUM,
		BLK_CUT
	} blk_kind_t;

	// Receiver session tracker plus the queue of replies it predicts
	class reply_scoreboard;
		bit          crc_mode;
		phase_t      ph;
		int          byte_cnt;
		logic [7:0]  blk_num;
		logic [7:0]  blk_comp;
		logic [7:0]  last_good;
		logic [7:0]  check_hi;
		logic [15:0] check_acc;
		rsp_t        expected_replies[$];
		int          mismatches;
		int          beats_in;
		int          beats_out;
		int          commits;
		int          discards;

		function new();
			crc_mode = 1'b1;
			ph = PH_IDLE;
			clear_session();
			mismatches = 0;
			beats_in = 0;
			beats_out = 0;
			commits = 0;
			discards = 0;
		endfunction

		function void clear_session();
			byte_cnt = 0;
			blk_num = '0;
			blk_comp = '0;
			last_good = '0;
			check_hi = '0;
			check_acc = '0;
		endfunction

		// CRC-16/XMODEM, fed one message bit at a time, MSB first
		static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[15] ^ b[i];
				c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
			end
			return c;
		endfunction

		// Verdict on a finished block: complement, then number, then check
		function rsp_t close_block(bit check_ok, rsp_t r);
			logic [7:0] next_num;
			next_num = last_good + 8'd1;
			r.reply_valid = 1'b1;
			if ({1'b0, blk_num} + {1'b0, blk_comp} != COMP_SUM) begin
				r.reply_byte = CH_NAK;
				r.block_discard = 1'b1;
				ph = PH_WAIT;
			end else if (blk_num != next_num) begin
				r.block_discard = 1'b1;
				if (blk_num == last_good) begin
					r.reply_byte = CH_ACK;
					ph = PH_WAIT;
				end else begin
					r.reply_byte = CH_CAN;
					r.reply_repeat = 4'(CANCEL_LEN);
					ph = PH_RCAN;
				end
			end else if (check_ok) begin
				r.reply_byte = CH_ACK;
				r.block_commit = 1'b1;
				last_good = next_num;
				ph = PH_WAIT;
			end else begin
				r.reply_byte = CH_NAK;
				r.block_discard = 1'b1;
				ph = PH_WAIT;
			end
			return r;
		endfunction

		// One accepted input beat -> one predicted reply
		function void accept_item(item_t it);
			rsp_t r;
			r = '0;
			r.reply_repeat = 4'd1;
			if (it.op == OP_START) begin
				clear_session();
				ph = PH_WAIT;
				r.reply_valid = 1'b1;
				r.reply_byte = crc_mode ? CH_C : CH_NAK;
			end else begin
				case (ph)
					PH_WAIT: begin
						if (it.rx_byte == CH_SOH) begin
							ph = PH_NUM;
							byte_cnt = 0;
							check_acc = '0;
						end else if (it.rx_byte == CH_EOT) begin
							r.reply_valid = 1'b1;
							r.reply_byte = CH_NAK;
							ph = PH_EOT;
						end else if (it.rx_byte == CH_CAN) begin
							ph = PH_CAN1;
						end
					end
					PH_CAN1: ph = (it.rx_byte == CH_CAN) ? PH_SCAN : PH_WAIT;
					PH_EOT: begin
						if (it.rx_byte == CH_EOT) begin
							r.reply_valid = 1'b1;
							r.reply_byte = CH_ACK;
							ph = PH_DONE;
						end
					end
					PH_NUM: begin
						blk_num = it.rx_byte;
						ph = PH_COMP;
					end
					PH_COMP: begin
						blk_comp = it.rx_byte;
						ph = PH_DATA;
					end
					PH_DATA: begin
						r.data_valid = 1'b1;
						r.data_byte = it.rx_byte;
						if (crc_mode)
							check_acc = crc_byte(check_acc, it.rx_byte);
						else
							check_acc = {8'h00, check_acc[7:0] + it.rx_byte};
						if (byte_cnt == PAYLOAD_LEN - 1) begin
							byte_cnt = 0;
							ph = PH_CHK1;
						end else begin
							byte_cnt++;
						end
					end
					PH_CHK1: begin
						if (crc_mode) begin
							check_hi = it.rx_byte;
							ph = PH_CHK2;
						end else begin
							r = close_block(check_acc[7:0] == it.rx_byte, r);
						end
					end
					PH_CHK2: r = close_block({check_hi, it.rx_byte} == check_acc, r);
					default: ;
				endcase
			end
			case (ph)
				PH_DONE: r.status = ST_DONE;
				PH_SCAN: r.status = ST_SCAN;
				PH_RCAN: r.status = ST_RCAN;
				default: r.status = ST_RUN;
			endcase
			expected_replies.push_back(r);
			beats_in++;
		endfunction

		task report(string what);
			mismatches++;
			$display("ERROR: %s", what);
		endtask

		task field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("reply %0d: %s is 0x%0h, want 0x%0h", beats_out, name, got, want));
		endtask

		task check_reply(rsp_t got);
			rsp_t want;
			beats_out++;
			if (expected_replies.size() == 0) begin
				report($sformatf("reply %0d arrived with nothing outstanding", beats_out));
			end else begin
				want = expected_replies.pop_front();
				field("reply_valid", got.reply_valid, want.reply_valid);
				field("reply_byte", got.reply_byte, want.reply_byte);
				field("reply_repeat", got.reply_repeat, want.reply_repeat);
				field("data_valid", got.data_valid, want.data_valid);
				field("data_byte", got.data_byte, want.data_byte);
				field("block_commit", got.block_commit, want.block_commit);
				field("block_discard", got.block_discard, want.block_discard);
				field("status", got.status, want.status);
				if (want.block_commit) commits++;
				if (want.block_discard) discards++;
			end
		endtask
	endclass

	logic  clk;
	logic  arst_n;
	logic  rx_valid;
	logic  rx_ready;
	item_t rx_item;
	logic  res_valid;
	logic  res_ready;
	rsp_t  res_item;
	logic  cfg_valid;
	logic  cfg_ready;
	logic  cfg_data;

	reply_scoreboard sb = new();

	int n_sessions = 0;
	int n_blocks = 0;
	int n_cfg_writes = 0;
	int n_mid_flips = 0;

	xmodem_block_receiver_unit #(
		.PAYLOAD_BYTES(PAYLOAD_LEN),
		.CANCEL_REPEAT(CANCEL_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_item(rx_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item(res_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// No idling on either side over a middle stretch of the run
	function automatic bit roll_idle();
		return !(sb.beats_in >= 500 && sb.beats_in < 800) && ($urandom_range(99) < 7);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_SOH || b == CH_EOT || b == CH_CAN);
		return b;
	endfunction

	// Offer one beat on rx, return once it is taken
	task automatic send_item(logic op, logic [7:0] b);
		item_t it;
		it.op = op;
		it.rx_byte = b;
		@(negedge clk);
		while (roll_idle()) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_item <= it;
		do @(posedge clk); while (!rx_ready);
		sb.accept_item(it);
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(OP_BYTE, b);
	endtask

	// Stop offering and wait for every outstanding reply
	task automatic drain();
		@(negedge clk);
		rx_valid <= 1'b0;
		while (sb.expected_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(bit v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.crc_mode = v;
		n_cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// SOH, number, complement, payload, check; shaped by kind
	task automatic send_block(blk_kind_t kind);
		logic [7:0]  num;
		logic [7:0]  comp;
		logic [7:0]  b;
		logic [15:0] sum;
		int          pattern;
		int          flip_at;
		int          cut_at;
		bit          mode;
		mode = sb.crc_mode;
		num = (kind == BLK_DUP) ? sb.last_good : sb.last_good + 8'd1;
		if (kind == BLK_BAD_NUM)
			do num = 8'($urandom); while (num == sb.last_good || num == sb.last_good + 8'd1);
		comp = 8'd255 - num;
		if (kind == BLK_BAD_COMP)
			do comp = 8'($urandom); while (comp == 8'd255 - num);
		pattern = $urandom_range(9);
		flip_at = ($urandom_range(14) == 0) ? $urandom_range(PAYLOAD_LEN - 1) : -1;
		cut_at = (kind == BLK_CUT) ? $urandom_range(PAYLOAD_LEN - 1) : PAYLOAD_LEN;
		sum = '0;
		send_byte(CH_SOH);
		send_byte(num);
		send_byte(comp);
		for (int i = 0; i < cut_at; i++) begin
			// mode change with the block part streamed
			if (i == flip_at) begin
				write_cfg(!sb.crc_mode);
				n_mid_flips++;
			end
			case (pattern)
				0: b = 8'h00;
				1: b = 8'hFF;
				2: b = LINE_CODES[$urandom_range(5)];
				default: b = 8'($urandom);
			endcase
			sum = mode ? reply_scoreboard::crc_byte(sum, b) : {8'h00, sum[7:0] + b};
			send_byte(b);
		end
		if (kind != BLK_CUT) begin
			if (kind == BLK_BAD_CHECK)
				sum ^= mode ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 255));
			if (sb.crc_mode) begin
				send_byte(sum[15:8]);
				send_byte(sum[7:0]);
			end else begin
				send_byte(sum[7:0]);
			end
			n_blocks++;
		end
	endtask

	// Start, a few blocks with some line noise, then a random ending
	task automatic run_session();
		int        n_blk;
		int        roll;
		logic [7:0] b;
		blk_kind_t kind;
		if ($urandom_range(2) == 0)
			write_cfg(1'($urandom_range(1)));
		send_item(OP_START, 8'($urandom));
		n_sessions++;
		n_blk = $urandom_range(1, 3);
		for (int k = 0; k < n_blk && sb.ph != PH_RCAN; k++) begin
			if ($urandom_range(6) == 0) begin
				if ($urandom_range(1)) begin
					// lone CAN swallows the byte after it
					do b = 8'($urandom); while (b == CH_CAN);
					send_byte(CH_CAN);
					send_byte(b);
				end else begin
					repeat ($urandom_range(1, 3)) send_byte(plain_byte());
				end
			end
			roll = $urandom_range(99);
			kind = roll < 55 ? BLK_GOOD :
				roll < 67 ? BLK_BAD_CHECK :
				roll < 77 ? BLK_BAD_COMP :
				roll < 87 ? BLK_DUP :
				roll < 93 ? BLK_BAD_NUM : BLK_CUT;
			send_block(kind);
			if (kind == BLK_CUT)
				return;
		end
		if (sb.ph == PH_RCAN) begin
			send_byte(8'($urandom));
			return;
		end
		case ($urandom_range(2))
			0: begin
				send_byte(CH_EOT);
				send_byte(plain_byte());
				send_byte(CH_EOT);
				send_byte(8'($urandom));
			end
			1: begin
				send_byte(CH_CAN);
				send_byte(CH_CAN);
			end
			default: ;
		endcase
	endtask

	// Result side: random ready, one long hold-off to back the block up
	initial begin
		bit held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held && sb.beats_out >= 400) begin
				held = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			res_ready <= !roll_idle();
		end
	end

	// Check each reply beat as it is taken
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_reply(res_item);
	end

	// Watchdog: too long with no beat on any channel
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (rx_valid && rx_ready) || (res_valid && res_ready) ||
				(cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("xmodem_block_receiver_unit test failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_item = '0;
		res_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// bytes before any start are ignored
		send_byte(8'hFF);
		send_byte(8'h00);
		write_cfg(1'b1);
		send_item(OP_START, 8'hFF);
		send_byte(8'h00);
		// lone CAN drops the next byte, even an SOH
		send_byte(CH_CAN);
		send_byte(CH_SOH);
		// EOT, junk, EOT ends the transfer; later bytes are ignored
		send_byte(CH_EOT);
		send_byte(8'h80);
		send_byte(CH_EOT);
		send_byte(CH_CAN);
		write_cfg(1'b0);
		send_item(OP_START, 8'h00);
		// double CAN from the sender
		send_byte(CH_CAN);
		send_byte(CH_CAN);
		send_byte(8'h7F);
		// start in the middle of the EOT handshake
		send_item(OP_START, 8'h5A);
		send_byte(CH_EOT);
		send_item(OP_START, 8'hA5);

		while (sb.beats_in < ITEM_TARGET)
			run_session();

		drain();
		repeat (10) @(posedge clk);
		$display("Run: %0d input beats, %0d sessions, %0d full blocks (%0d kept, %0d dropped).",
			sb.beats_in, n_sessions, n_blocks, sb.commits, sb.discards);
		$display("Mode written %0d times, %0d mid-block; %0d field mismatches.",
			n_cfg_writes, n_mid_flips, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_replies.size() == 0) begin
			$display("xmodem_block_receiver_unit test passed");
		end else begin
			$display("xmodem_block_receiver_unit test failed");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/xmbr_pkg.sv
hw/rtl/xmbr_front.sv
hw/rtl/xmbr_queue.sv
hw/rtl/xmbr_back.sv
hw/rtl/xmodem_block_receiver_unit.sv
hw/rtl/xmbr_checker.sv
bench/tb_xmodem_block_receiver_unit.sv
